// File: src/printf_conversion_spec_parser_assert.svh
// ----------------------------------------------------------------------------
// printf conversion spec parser assertion macros
// shared property wrappers clocked on i_clk and disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef PRINTF_CONVERSION_SPEC_PARSER_ASSERT_SVH
`define PRINTF_CONVERSION_SPEC_PARSER_ASSERT_SVH

// same-cycle implication
`define PCSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PCSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/pcsp_pkg.sv
// ----------------------------------------------------------------------------
// pcsp_pkg
// types, character codes and helper functions of the conversion spec parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcsp_pkg;

    localparam int unsigned ACC_W    = 35;
    localparam int unsigned NUM_W    = 32;
    localparam int unsigned RESULT_W = 185;
    localparam int unsigned TDATA_W  = 192;

    localparam logic [ACC_W-1:0] NUM_LIMIT = 35'h0_8000_0000;

    // character codes
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_HASH   = 8'h23;
    localparam logic [7:0] C_DOLLAR = 8'h24;
    localparam logic [7:0] C_QUOTE  = 8'h27;
    localparam logic [7:0] C_STAR   = 8'h2A;
    localparam logic [7:0] C_PLUS   = 8'h2B;
    localparam logic [7:0] C_MINUS  = 8'h2D;
    localparam logic [7:0] C_DOT    = 8'h2E;
    localparam logic [7:0] C_ZERO   = 8'h30;
    localparam logic [7:0] C_NINE   = 8'h39;
    localparam logic [7:0] C_H      = 8'h68;
    localparam logic [7:0] C_L      = 8'h6C;

    // flag bits
    localparam logic [5:0] F_ALT   = 6'h01;
    localparam logic [5:0] F_ZERO  = 6'h02;
    localparam logic [5:0] F_LEFT  = 6'h04;
    localparam logic [5:0] F_SPACE = 6'h08;
    localparam logic [5:0] F_PLUS  = 6'h10;
    localparam logic [5:0] F_GROUP = 6'h20;

    // mode bits
    localparam logic [2:0] M_WSTAR = 3'h1;
    localparam logic [2:0] M_PREC  = 3'h2;
    localparam logic [2:0] M_PSTAR = 3'h4;

    typedef enum logic [3:0] {
        PH_IDLE, PH_START, PH_LEADRUN, PH_FLAGS, PH_WSTART, PH_WDIG, PH_WSTAR,
        PH_WSTARRUN, PH_AFTERW, PH_PSTART, PH_PDIG, PH_PSTAR, PH_PSTARRUN, PH_MODS
    } t_phase;

    typedef struct packed {
        logic       valid;
        logic [7:0] ch;
    } t_pcsp_in_item;

    typedef struct packed {
        logic [7:0]       rewind_count;
        logic [7:0]       conversion_type;
        logic [NUM_W-1:0] precision_index;
        logic [NUM_W-1:0] precision_value;
        logic             precision_star;
        logic             precision_present;
        logic [NUM_W-1:0] width_index;
        logic             width_star;
        logic [NUM_W-1:0] width_value;
        logic [5:0]       flag_bits;
        logic [NUM_W-1:0] data_index;
    } t_pcsp_result;

    typedef struct packed {
        logic         valid;
        t_pcsp_result res;
    } t_pcsp_emit;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= C_ZERO) && (c <= C_NINE);
    endfunction

    // value*10 + digit while below the limit
    function automatic logic [ACC_W-1:0] acc_take(input logic [ACC_W-1:0] acc,
                                                 input logic [7:0] c);
        logic [ACC_W-1:0] d;
        d = {27'd0, 8'(c - C_ZERO)};
        if (acc < NUM_LIMIT) begin
            return (acc << 3) + (acc << 1) + d;
        end
        return acc;
    endfunction

    function automatic logic [NUM_W-1:0] run_value(input logic [ACC_W-1:0] acc);
        return (acc > NUM_LIMIT) ? '0 : acc[NUM_W-1:0];
    endfunction

    // result packed from the lowest bit up, zero filled to whole bytes
    function automatic logic [TDATA_W-1:0] pack_result(input t_pcsp_result r);
        return {{(TDATA_W-RESULT_W){1'b0}}, r};
    endfunction

endpackage

// File: src/printf_conversion_spec_parser.sv
// ----------------------------------------------------------------------------
// printf_conversion_spec_parser
// parses printf conversion specs from a byte stream, one result per spec
// ----------------------------------------------------------------------------
// usage
//   slave side carries one format byte per transaction in tdata[7:0]; the
//   first byte of every spec is the introducer and is skipped
//   master side carries one result per spec, sent when the type byte or the end of a star run lands
//   bytes that end no spec produce no master transaction
// timing
//   one byte per cycle sustained while the result register has room: a byte
//   is held in the input register, and the parse step is combinational between
//   that register and the result register
//   the type byte passes the input register and then the result register
//   before tvalid rises on the master side
// reset
//   synchronous active-low i_rst_n empties both registers and puts the parser
//   back to awaiting an introducer
// back pressure
//   a waiting result blocks the parse step only; one more byte is still taken
//   into the input register, after which tready drops until the result leaves
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "printf_conversion_spec_parser_assert.svh"

module printf_conversion_spec_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave side
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,  // [7:0] ch
    // master side
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] data_index, [37:32] flag_bits, [69:38] width_value, [70] width_star,
    // [102:71] width_index, [103] precision_present, [104] precision_star,
    // [136:105] precision_value, [168:137] precision_index,
    // [176:169] conversion_type, [184:177] rewind_count, [191:185] zero
    output logic [191:0] o_m_axis_tdata
);

    pcsp_pkg::t_pcsp_in_item w_item;
    pcsp_pkg::t_pcsp_emit    w_emit;
    pcsp_pkg::t_pcsp_result  w_res;
    logic                    w_space;
    logic                    w_adv;

    // parse step fires when a byte is held and the result register has room
    assign w_adv = w_item.valid && w_space;

    pcsp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_data  (i_s_axis_tdata),
        .o_ready (o_s_axis_tready),
        .i_adv   (w_adv),
        .o_item  (w_item)
    );

    pcsp_parse_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_item  (w_item),
        .o_emit  (w_emit)
    );

    pcsp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (w_emit),
        .o_space (w_space),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_res)
    );

    assign o_m_axis_tdata = pcsp_pkg::pack_result(w_res);

    // a replay count only comes from a star run without dollar
    `PCSP_ASSERT_SAME(a_rewind_star,
        o_m_axis_tvalid && o_m_axis_tdata[184:177] != 8'd0,
        o_m_axis_tdata[70] || o_m_axis_tdata[104], "rewind without star")
    // star precision implies a dot was seen
    `PCSP_ASSERT_SAME(a_pstar_prec, o_m_axis_tvalid && o_m_axis_tdata[104],
        o_m_axis_tdata[103], "precision star without dot")
    // left justify overrides zero pad, plus overrides space
    `PCSP_ASSERT_SAME(a_flag_excl, o_m_axis_tvalid,
        !(o_m_axis_tdata[33] && o_m_axis_tdata[34]) &&
        !(o_m_axis_tdata[35] && o_m_axis_tdata[36]), "conflicting flags")
    // a taken result is not shown again unless a new one was loaded
    `PCSP_ASSERT_NEXT(a_no_repeat,
        o_m_axis_tvalid && i_m_axis_tready && !w_emit.valid,
        !o_m_axis_tvalid, "result repeated")

endmodule

// File: src/pcsp_in_stage.sv
// ----------------------------------------------------------------------------
// pcsp_in_stage
// input register holding one character transaction for the parse core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcsp_in_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_data,
    output logic                   o_ready,
    input  logic                   i_adv,
    output pcsp_pkg::t_pcsp_in_item o_item
);

    logic       r_valid;
    logic [7:0] r_ch;

    assign o_ready = !r_valid || i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch <= i_data;
        end
    end

    assign o_item.valid = r_valid;
    assign o_item.ch    = r_ch;

endmodule

// File: src/pcsp_parse_core.sv
// ----------------------------------------------------------------------------
// pcsp_parse_core
// parse state and stores, one character consumed per advance
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcsp_parse_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_adv,
    input  pcsp_pkg::t_pcsp_in_item i_item,
    output pcsp_pkg::t_pcsp_emit    o_emit
);

    pcsp_pkg::t_phase r_phase, n_phase;
    logic [pcsp_pkg::ACC_W-1:0] r_acc, n_acc;
    logic [7:0] r_cnt, n_cnt;
    logic       r_nz, n_nz;
    logic [7:0] r_first, n_first;
    logic [5:0] r_flags, n_flags;
    logic [pcsp_pkg::NUM_W-1:0] r_didx, n_didx;
    logic [pcsp_pkg::NUM_W-1:0] r_w, n_w;
    logic [pcsp_pkg::NUM_W-1:0] r_widx, n_widx;
    logic [pcsp_pkg::NUM_W-1:0] r_p, n_p;
    logic [pcsp_pkg::NUM_W-1:0] r_pidx, n_pidx;
    logic [2:0] r_mode, n_mode;

    // working values through the chain of phases one character can visit
    pcsp_pkg::t_phase v_ph;
    logic       v_done;
    logic       v_emit;
    logic [7:0] v_type;
    logic [7:0] v_rew;
    logic [pcsp_pkg::ACC_W-1:0] v_acc;
    logic [7:0] v_cnt;
    logic       v_nz;
    logic [7:0] v_first;
    logic [5:0] v_flags;
    logic [pcsp_pkg::NUM_W-1:0] v_didx, v_w, v_widx, v_p, v_pidx;
    logic [2:0] v_mode;
    logic [7:0] c;
    logic       dig;

    assign c   = i_item.ch;
    assign dig = pcsp_pkg::is_digit(c);

    // next state: phases only fall forward, so one ordered pass covers every chain
    always_comb begin
        v_ph    = r_phase;
        v_done  = 1'b0;
        v_emit  = 1'b0;
        v_type  = c;
        v_rew   = 8'd0;
        v_acc   = r_acc;
        v_cnt   = r_cnt;
        v_nz    = r_nz;
        v_first = r_first;
        v_flags = r_flags;
        v_didx  = r_didx;
        v_w     = r_w;
        v_widx  = r_widx;
        v_p     = r_p;
        v_pidx  = r_pidx;
        v_mode  = r_mode;

        // introducer: skipped, new spec with cleared stores
        if (v_ph == pcsp_pkg::PH_IDLE) begin
            v_acc   = '0;
            v_cnt   = 8'd0;
            v_nz    = 1'b0;
            v_first = 8'd0;
            v_flags = 6'd0;
            v_didx  = '0;
            v_w     = '0;
            v_widx  = '0;
            v_p     = '0;
            v_pidx  = '0;
            v_mode  = 3'd0;
            v_ph    = pcsp_pkg::PH_START;
            v_done  = 1'b1;
        end

        if (!v_done && v_ph == pcsp_pkg::PH_START) begin
            priority if (dig) begin
                v_acc   = pcsp_pkg::acc_take('0, c);
                v_cnt   = 8'd1;
                v_nz    = (c != pcsp_pkg::C_ZERO);
                v_first = c;
                v_ph    = pcsp_pkg::PH_LEADRUN;
                v_done  = 1'b1;
            end else if (c == pcsp_pkg::C_DOLLAR) begin
                v_didx = '0;
                v_ph   = pcsp_pkg::PH_FLAGS;
                v_done = 1'b1;
            end else begin
                v_ph = pcsp_pkg::PH_FLAGS;
            end
        end

        if (!v_done && v_ph == pcsp_pkg::PH_LEADRUN) begin
            priority if (dig) begin
                v_acc  = pcsp_pkg::acc_take(v_acc, c);
                v_cnt  = (v_cnt == 8'hFF) ? v_cnt : v_cnt + 8'd1;
                v_nz   = v_nz || (c != pcsp_pkg::C_ZERO);
                v_done = 1'b1;
            end else if (c == pcsp_pkg::C_DOLLAR) begin
                v_didx = pcsp_pkg::run_value(v_acc);
                v_ph   = pcsp_pkg::PH_FLAGS;
                v_done = 1'b1;
            end else begin
                // leading run without dollar: zero pad flag and/or width
                v_flags = (v_first == pcsp_pkg::C_ZERO) ? pcsp_pkg::F_ZERO : 6'd0;
                if (v_nz) begin
                    v_w  = pcsp_pkg::run_value(v_acc);
                    v_ph = pcsp_pkg::PH_AFTERW;
                end else begin
                    v_ph = pcsp_pkg::PH_FLAGS;
                end
            end
        end

        if (!v_done && v_ph == pcsp_pkg::PH_FLAGS) begin
            v_done = 1'b1;
            priority if (c == pcsp_pkg::C_HASH) begin
                v_flags = v_flags | pcsp_pkg::F_ALT;
            end else if (c == pcsp_pkg::C_ZERO && (v_flags & pcsp_pkg::F_LEFT) == 6'd0) begin
                v_flags = v_flags | pcsp_pkg::F_ZERO;
            end else if (c == pcsp_pkg::C_MINUS) begin
                v_flags = (v_flags | pcsp_pkg::F_LEFT) & ~pcsp_pkg::F_ZERO;
            end else if (c == pcsp_pkg::C_SPACE && (v_flags & pcsp_pkg::F_PLUS) == 6'd0) begin
                v_flags = v_flags | pcsp_pkg::F_SPACE;
            end else if (c == pcsp_pkg::C_PLUS) begin
                v_flags = (v_flags | pcsp_pkg::F_PLUS) & ~pcsp_pkg::F_SPACE;
            end else if (c == pcsp_pkg::C_QUOTE) begin
                v_flags = v_flags | pcsp_pkg::F_GROUP;
            end else begin
                v_ph   = pcsp_pkg::PH_WSTART;
                v_done = 1'b0;
            end
        end

        if (!v_done && v_ph == pcsp_pkg::PH_WSTART) begin
            priority if (c == pcsp_pkg::C_STAR) begin
                v_mode = v_mode | pcsp_pkg::M_WSTAR;
                v_ph   = pcsp_pkg::PH_WSTAR;
                v_done = 1'b1;
            end else if (dig) begin
                v_acc   = pcsp_pkg::acc_take('0, c);
                v_cnt   = 8'd1;
                v_nz    = (c != pcsp_pkg::C_ZERO);
                v_first = c;
                v_ph    = pcsp_pkg::PH_WDIG;
                v_done  = 1'b1;
            end else begin
                v_w  = '0;
                v_ph = pcsp_pkg::PH_AFTERW;
            end
        end

        if (!v_done && v_ph == pcsp_pkg::PH_WDIG) begin
            if (dig) begin
                v_acc  = pcsp_pkg::acc_take(v_acc, c);
                v_cnt  = (v_cnt == 8'hFF) ? v_cnt : v_cnt + 8'd1;
                v_nz   = v_nz || (c != pcsp_pkg::C_ZERO);
                v_done = 1'b1;
            end else begin
                v_w  = pcsp_pkg::run_value(v_acc);
                v_ph = pcsp_pkg::PH_AFTERW;
            end
        end

        if (!v_done && v_ph == pcsp_pkg::PH_WSTAR) begin
            priority if (dig) begin
                v_acc   = pcsp_pkg::acc_take('0, c);
                v_cnt   = 8'd1;
                v_nz    = (c != pcsp_pkg::C_ZERO);
                v_first = c;
                v_ph    = pcsp_pkg::PH_WSTARRUN;
                v_done  = 1'b1;
            end else if (c == pcsp_pkg::C_DOLLAR) begin
                v_widx = '0;
                v_ph   = pcsp_pkg::PH_AFTERW;
                v_done = 1'b1;
            end else begin
                v_widx = '0;
                v_ph   = pcsp_pkg::PH_AFTERW;
            end
        end

        if (!v_done && v_ph == pcsp_pkg::PH_WSTARRUN) begin
            v_done = 1'b1;
            priority if (dig) begin
                v_acc = pcsp_pkg::acc_take(v_acc, c);
                v_cnt = (v_cnt == 8'hFF) ? v_cnt : v_cnt + 8'd1;
                v_nz  = v_nz || (c != pcsp_pkg::C_ZERO);
            end else if (c == pcsp_pkg::C_DOLLAR) begin
                v_widx = pcsp_pkg::run_value(v_acc);
                v_ph   = pcsp_pkg::PH_AFTERW;
            end else begin
                // star run without dollar ends the spec, rest is replayed
                v_widx = '0;
                v_emit = 1'b1;
                v_type = v_first;
                v_rew  = v_cnt;
            end
        end

        if (!v_done && v_ph == pcsp_pkg::PH_AFTERW) begin
            if (c == pcsp_pkg::C_DOT) begin
                v_mode = v_mode | pcsp_pkg::M_PREC;
                v_ph   = pcsp_pkg::PH_PSTART;
                v_done = 1'b1;
            end else begin
                v_ph = pcsp_pkg::PH_MODS;
            end
        end

        if (!v_done && v_ph == pcsp_pkg::PH_PSTART) begin
            priority if (c == pcsp_pkg::C_STAR) begin
                v_mode = v_mode | pcsp_pkg::M_PSTAR;
                v_ph   = pcsp_pkg::PH_PSTAR;
                v_done = 1'b1;
            end else if (dig) begin
                v_acc   = pcsp_pkg::acc_take('0, c);
                v_cnt   = 8'd1;
                v_nz    = (c != pcsp_pkg::C_ZERO);
                v_first = c;
                v_ph    = pcsp_pkg::PH_PDIG;
                v_done  = 1'b1;
            end else begin
                v_p  = '0;
                v_ph = pcsp_pkg::PH_MODS;
            end
        end

        if (!v_done && v_ph == pcsp_pkg::PH_PDIG) begin
            if (dig) begin
                v_acc  = pcsp_pkg::acc_take(v_acc, c);
                v_cnt  = (v_cnt == 8'hFF) ? v_cnt : v_cnt + 8'd1;
                v_nz   = v_nz || (c != pcsp_pkg::C_ZERO);
                v_done = 1'b1;
            end else begin
                v_p  = pcsp_pkg::run_value(v_acc);
                v_ph = pcsp_pkg::PH_MODS;
            end
        end

        if (!v_done && v_ph == pcsp_pkg::PH_PSTAR) begin
            priority if (dig) begin
                v_acc   = pcsp_pkg::acc_take('0, c);
                v_cnt   = 8'd1;
                v_nz    = (c != pcsp_pkg::C_ZERO);
                v_first = c;
                v_ph    = pcsp_pkg::PH_PSTARRUN;
                v_done  = 1'b1;
            end else if (c == pcsp_pkg::C_DOLLAR) begin
                v_pidx = '0;
                v_ph   = pcsp_pkg::PH_MODS;
                v_done = 1'b1;
            end else begin
                v_pidx = '0;
                v_ph   = pcsp_pkg::PH_MODS;
            end
        end

        if (!v_done && v_ph == pcsp_pkg::PH_PSTARRUN) begin
            v_done = 1'b1;
            priority if (dig) begin
                v_acc = pcsp_pkg::acc_take(v_acc, c);
                v_cnt = (v_cnt == 8'hFF) ? v_cnt : v_cnt + 8'd1;
                v_nz  = v_nz || (c != pcsp_pkg::C_ZERO);
            end else if (c == pcsp_pkg::C_DOLLAR) begin
                v_pidx = pcsp_pkg::run_value(v_acc);
                v_ph   = pcsp_pkg::PH_MODS;
            end else begin
                v_pidx = '0;
                v_emit = 1'b1;
                v_type = v_first;
                v_rew  = v_cnt;
            end
        end

        if (!v_done && v_ph == pcsp_pkg::PH_MODS) begin
            v_done = 1'b1;
            // length modifiers skipped, anything else is the type
            if (c != pcsp_pkg::C_H && c != pcsp_pkg::C_L) begin
                v_emit = 1'b1;
                v_type = c;
                v_rew  = 8'd0;
            end
        end

        if (v_emit) begin
            n_phase = pcsp_pkg::PH_IDLE;
            n_acc   = '0;
            n_cnt   = 8'd0;
            n_nz    = 1'b0;
            n_first = 8'd0;
            n_flags = 6'd0;
            n_didx  = '0;
            n_w     = '0;
            n_widx  = '0;
            n_p     = '0;
            n_pidx  = '0;
            n_mode  = 3'd0;
        end else begin
            n_phase = v_ph;
            n_acc   = v_acc;
            n_cnt   = v_cnt;
            n_nz    = v_nz;
            n_first = v_first;
            n_flags = v_flags;
            n_didx  = v_didx;
            n_w     = v_w;
            n_widx  = v_widx;
            n_p     = v_p;
            n_pidx  = v_pidx;
            n_mode  = v_mode;
        end
    end

    // outputs: result taken from the stores as they stand when the type lands
    always_comb begin
        o_emit.valid                 = i_adv && v_emit;
        o_emit.res.data_index        = v_didx;
        o_emit.res.flag_bits         = v_flags;
        o_emit.res.width_value       = v_w;
        o_emit.res.width_star        = v_mode[0];
        o_emit.res.width_index       = v_widx;
        o_emit.res.precision_present = v_mode[1];
        o_emit.res.precision_star    = v_mode[2];
        o_emit.res.precision_value   = v_p;
        o_emit.res.precision_index   = v_pidx;
        o_emit.res.conversion_type   = v_type;
        o_emit.res.rewind_count      = v_rew;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pcsp_pkg::PH_IDLE;
        end else if (i_adv) begin
            r_phase <= n_phase;
        end
    end

    // stores are cleared by the introducer step, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_nz    <= n_nz;
            r_first <= n_first;
            r_flags <= n_flags;
            r_didx  <= n_didx;
            r_w     <= n_w;
            r_widx  <= n_widx;
            r_p     <= n_p;
            r_pidx  <= n_pidx;
            r_mode  <= n_mode;
        end
    end

endmodule

// File: src/pcsp_out_stage.sv
// ----------------------------------------------------------------------------
// pcsp_out_stage
// result register towards the master side
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcsp_out_stage (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pcsp_pkg::t_pcsp_emit   i_emit,
    output logic                   o_space,
    output logic                   o_valid,
    input  logic                   i_ready,
    output pcsp_pkg::t_pcsp_result o_res
);

    logic                   r_valid;
    pcsp_pkg::t_pcsp_result r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.valid) begin
            r_res <= i_emit.res;
        end
    end

endmodule

// File: verif/pcsp_checker.sv
// ----------------------------------------------------------------------------
// pcsp_checker
// watches both stream channels of the conversion spec parser, predicts every
// result from the accepted format bytes and compares the results field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcsp_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  logic [7:0]   i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  logic [191:0] i_out_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_specs_seen
);

    localparam int unsigned RES_W = $bits(pcsp_pkg::t_pcsp_result);

    // parser state mirror
    pcsp_pkg::t_phase           ph;
    logic [pcsp_pkg::ACC_W-1:0] acc;
    logic [7:0]                 run_len;
    logic                       run_nz;
    logic [7:0]                 run_first;
    logic [5:0]                 flags;
    logic [31:0]                didx;
    logic [31:0]                wval;
    logic [31:0]                widx;
    logic [31:0]                pval;
    logic [31:0]                pidx;
    logic [2:0]                 mode;

    pcsp_pkg::t_pcsp_result expected_specs[$];
    int                     mismatches = 0;
    int                     specs_seen = 0;

    function automatic logic is_dec(input logic [7:0] c);
        return (c[7:4] == 4'h3) && (c[3:0] <= 4'd9);
    endfunction

    function automatic logic [31:0] run_num();
        if (acc > pcsp_pkg::NUM_LIMIT) begin
            return 32'd0;
        end
        return acc[31:0];
    endfunction

    task automatic wipe();
        acc = '0; run_len = '0; run_nz = 1'b0; run_first = '0; flags = '0;
        didx = '0; wval = '0; widx = '0; pval = '0; pidx = '0; mode = '0;
    endtask

    task automatic grow(input logic [7:0] c);
        if (acc < pcsp_pkg::NUM_LIMIT) begin
            acc = acc * 35'd10 + 35'(c[3:0]);
        end
        if (run_len != 8'hFF) begin
            run_len = run_len + 8'd1;
        end
        if (c != pcsp_pkg::C_ZERO) begin
            run_nz = 1'b1;
        end
    endtask

    task automatic open_run(input logic [7:0] c);
        acc = '0; run_len = '0; run_nz = 1'b0;
        run_first = c;
        grow(c);
    endtask

    task automatic close_spec(input logic [7:0] conv, input logic [7:0] rewind,
                              output pcsp_pkg::t_pcsp_result r);
        r.data_index        = didx;
        r.flag_bits         = flags;
        r.width_value       = wval;
        r.width_star        = |(mode & pcsp_pkg::M_WSTAR);
        r.width_index       = widx;
        r.precision_present = |(mode & pcsp_pkg::M_PREC);
        r.precision_star    = |(mode & pcsp_pkg::M_PSTAR);
        r.precision_value   = pval;
        r.precision_index   = pidx;
        r.conversion_type   = conv;
        r.rewind_count      = rewind;
        ph = pcsp_pkg::PH_IDLE;
        wipe();
    endtask

    // one format byte through the parser; hit is set when a spec completes
    task automatic parse_byte(input logic [7:0] c, output logic hit,
                              output pcsp_pkg::t_pcsp_result r);
        logic again;
        hit = 1'b0;
        r = '0;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            unique case (ph)
                pcsp_pkg::PH_START: begin
                    if (is_dec(c)) begin
                        open_run(c);
                        ph = pcsp_pkg::PH_LEADRUN;
                    end else if (c == pcsp_pkg::C_DOLLAR) begin
                        didx = '0;
                        ph = pcsp_pkg::PH_FLAGS;
                    end else begin
                        ph = pcsp_pkg::PH_FLAGS;
                        again = 1'b1;
                    end
                end
                pcsp_pkg::PH_LEADRUN: begin
                    if (is_dec(c)) begin
                        grow(c);
                    end else if (c == pcsp_pkg::C_DOLLAR) begin
                        didx = run_num();
                        ph = pcsp_pkg::PH_FLAGS;
                    end else begin
                        // leading run was no index: zero pad and/or width
                        flags = (run_first == pcsp_pkg::C_ZERO) ? pcsp_pkg::F_ZERO : 6'h00;
                        if (run_nz) begin
                            wval = run_num();
                            ph = pcsp_pkg::PH_AFTERW;
                        end else begin
                            ph = pcsp_pkg::PH_FLAGS;
                        end
                        again = 1'b1;
                    end
                end
                pcsp_pkg::PH_FLAGS: begin
                    if (c == pcsp_pkg::C_HASH) begin
                        flags = flags | pcsp_pkg::F_ALT;
                    end else if (c == pcsp_pkg::C_ZERO &&
                                 (flags & pcsp_pkg::F_LEFT) == '0) begin
                        flags = flags | pcsp_pkg::F_ZERO;
                    end else if (c == pcsp_pkg::C_MINUS) begin
                        flags = (flags | pcsp_pkg::F_LEFT) & ~pcsp_pkg::F_ZERO;
                    end else if (c == pcsp_pkg::C_SPACE &&
                                 (flags & pcsp_pkg::F_PLUS) == '0) begin
                        flags = flags | pcsp_pkg::F_SPACE;
                    end else if (c == pcsp_pkg::C_PLUS) begin
                        flags = (flags | pcsp_pkg::F_PLUS) & ~pcsp_pkg::F_SPACE;
                    end else if (c == pcsp_pkg::C_QUOTE) begin
                        flags = flags | pcsp_pkg::F_GROUP;
                    end else begin
                        ph = pcsp_pkg::PH_WSTART;
                        again = 1'b1;
                    end
                end
                pcsp_pkg::PH_WSTART: begin
                    if (c == pcsp_pkg::C_STAR) begin
                        mode = mode | pcsp_pkg::M_WSTAR;
                        ph = pcsp_pkg::PH_WSTAR;
                    end else if (is_dec(c)) begin
                        open_run(c);
                        ph = pcsp_pkg::PH_WDIG;
                    end else begin
                        wval = '0;
                        ph = pcsp_pkg::PH_AFTERW;
                        again = 1'b1;
                    end
                end
                pcsp_pkg::PH_WDIG: begin
                    if (is_dec(c)) begin
                        grow(c);
                    end else begin
                        wval = run_num();
                        ph = pcsp_pkg::PH_AFTERW;
                        again = 1'b1;
                    end
                end
                pcsp_pkg::PH_WSTAR: begin
                    if (is_dec(c)) begin
                        open_run(c);
                        ph = pcsp_pkg::PH_WSTARRUN;
                    end else if (c == pcsp_pkg::C_DOLLAR) begin
                        widx = '0;
                        ph = pcsp_pkg::PH_AFTERW;
                    end else begin
                        widx = '0;
                        ph = pcsp_pkg::PH_AFTERW;
                        again = 1'b1;
                    end
                end
                pcsp_pkg::PH_WSTARRUN: begin
                    if (is_dec(c)) begin
                        grow(c);
                    end else if (c == pcsp_pkg::C_DOLLAR) begin
                        widx = run_num();
                        ph = pcsp_pkg::PH_AFTERW;
                    end else begin
                        // star run without dollar ends the spec early
                        widx = '0;
                        close_spec(run_first, run_len, r);
                        hit = 1'b1;
                    end
                end
                pcsp_pkg::PH_AFTERW: begin
                    if (c == pcsp_pkg::C_DOT) begin
                        mode = mode | pcsp_pkg::M_PREC;
                        ph = pcsp_pkg::PH_PSTART;
                    end else begin
                        ph = pcsp_pkg::PH_MODS;
                        again = 1'b1;
                    end
                end
                pcsp_pkg::PH_PSTART: begin
                    if (c == pcsp_pkg::C_STAR) begin
                        mode = mode | pcsp_pkg::M_PSTAR;
                        ph = pcsp_pkg::PH_PSTAR;
                    end else if (is_dec(c)) begin
                        open_run(c);
                        ph = pcsp_pkg::PH_PDIG;
                    end else begin
                        pval = '0;
                        ph = pcsp_pkg::PH_MODS;
                        again = 1'b1;
                    end
                end
                pcsp_pkg::PH_PDIG: begin
                    if (is_dec(c)) begin
                        grow(c);
                    end else begin
                        pval = run_num();
                        ph = pcsp_pkg::PH_MODS;
                        again = 1'b1;
                    end
                end
                pcsp_pkg::PH_PSTAR: begin
                    if (is_dec(c)) begin
                        open_run(c);
                        ph = pcsp_pkg::PH_PSTARRUN;
                    end else if (c == pcsp_pkg::C_DOLLAR) begin
                        pidx = '0;
                        ph = pcsp_pkg::PH_MODS;
                    end else begin
                        pidx = '0;
                        ph = pcsp_pkg::PH_MODS;
                        again = 1'b1;
                    end
                end
                pcsp_pkg::PH_PSTARRUN: begin
                    if (is_dec(c)) begin
                        grow(c);
                    end else if (c == pcsp_pkg::C_DOLLAR) begin
                        pidx = run_num();
                        ph = pcsp_pkg::PH_MODS;
                    end else begin
                        pidx = '0;
                        close_spec(run_first, run_len, r);
                        hit = 1'b1;
                    end
                end
                pcsp_pkg::PH_MODS: begin
                    if (c != pcsp_pkg::C_H && c != pcsp_pkg::C_L) begin
                        close_spec(c, 8'd0, r);
                        hit = 1'b1;
                    end
                end
                default: begin
                    // introducer skipped
                    wipe();
                    ph = pcsp_pkg::PH_START;
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            if (mismatches < 10) begin
                $display("mismatch in %s of spec %0d: expected %0d, got %0d",
                         name, specs_seen, want, got);
            end
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        logic                   hit;
        pcsp_pkg::t_pcsp_result next_spec;
        pcsp_pkg::t_pcsp_result want;
        pcsp_pkg::t_pcsp_result got;
        if (!i_rst_n) begin
            ph = pcsp_pkg::PH_IDLE;
            wipe();
            expected_specs.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                parse_byte(i_in_data, hit, next_spec);
                if (hit) begin
                    expected_specs.push_back(next_spec);
                end
            end
            if (i_out_valid && i_out_ready) begin
                got = i_out_data[RES_W-1:0];
                if (expected_specs.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result transaction, type %0d, rewind %0d",
                                 got.conversion_type, got.rewind_count);
                    end
                    mismatches++;
                end else begin
                    want = expected_specs.pop_front();
                    check_field("data_index", want.data_index, got.data_index);
                    check_field("flag_bits", 32'(want.flag_bits), 32'(got.flag_bits));
                    check_field("width_value", want.width_value, got.width_value);
                    check_field("width_star", 32'(want.width_star), 32'(got.width_star));
                    check_field("width_index", want.width_index, got.width_index);
                    check_field("precision_present", 32'(want.precision_present),
                                32'(got.precision_present));
                    check_field("precision_star", 32'(want.precision_star),
                                32'(got.precision_star));
                    check_field("precision_value", want.precision_value,
                                got.precision_value);
                    check_field("precision_index", want.precision_index,
                                got.precision_index);
                    check_field("conversion_type", 32'(want.conversion_type),
                                32'(got.conversion_type));
                    check_field("rewind_count", 32'(want.rewind_count),
                                32'(got.rewind_count));
                    check_field("zero fill", 32'd0, 32'(i_out_data[191:RES_W]));
                    specs_seen++;
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_specs.size();
        o_specs_seen <= specs_seen;
    end

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives printf conversion specs into the parser byte by byte and checks
// every result through pcsp_checker, under three handshake idling profiles
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    // cycles without any transaction before the run is declared hung
    localparam int WATCHDOG_LIMIT = 2000;
    // random format bytes per idling profile
    localparam int BYTES_PER_PROFILE = 250;
    // cycles left for stray results once nothing is expected
    localparam int DRAIN_CYCLES = 16;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [191:0] m_tdata;

    int fail_count;
    int pending;
    int specs_seen;

    int tx_idle_pct = 6;
    int rx_idle_pct = 57;
    int bytes_sent = 0;
    int idle_cycles = 0;

    // format bytes waiting to be sent
    logic [7:0] format_q[$];

    always #5 clk = ~clk;

    printf_conversion_spec_parser dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    pcsp_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_tready),
        .i_in_data    (s_tdata),
        .i_out_valid  (m_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_specs_seen (specs_seen)
    );

    // receiver stalls at random according to the current profile
    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // hang detection: any transaction on either side restarts the count
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one byte transaction, preceded by random sender gaps
    task automatic send_format_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic flush_format();
        while (format_q.size() > 0) begin
            send_format_byte(format_q.pop_front());
        end
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            format_q.push_back(s[i]);
        end
    endtask

    task automatic put_digits(input int n);
        repeat (n) format_q.push_back(pcsp_pkg::C_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // a decimal number: mostly short, sometimes around or past 2^31
    task automatic put_number();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            format_q.push_back(pcsp_pkg::C_ZERO + 8'($urandom_range(1, 9)));
            put_digits($urandom_range(0, 2));
        end else if (pick < 70) begin
            // leading zeros in front of the value
            repeat ($urandom_range(1, 3)) format_q.push_back(pcsp_pkg::C_ZERO);
            put_digits($urandom_range(1, 3));
        end else if (pick < 82) begin
            // far past the limit, accumulation stops
            put_digits($urandom_range(10, 14));
        end else if (pick < 88) begin
            put_text("2147483648");
        end else if (pick < 92) begin
            put_text("2147483649");
        end else if (pick < 96) begin
            put_text("2147483647");
        end else begin
            format_q.push_back(pcsp_pkg::C_ZERO);
        end
    endtask

    task automatic put_conversion();
        string conv_chars;
        conv_chars = "diouxXcspfegn%";
        if ($urandom_range(0, 99) < 80) begin
            format_q.push_back(conv_chars[$urandom_range(0, conv_chars.len() - 1)]);
        end else begin
            format_q.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // one random spec, mostly well formed with random content
    task automatic put_spec();
        string flag_chars;
        int    pick;
        logic  lead_width;
        flag_chars = "#0- +'";
        lead_width = 1'b0;

        // plain noise
        if ($urandom_range(0, 99) < 8) begin
            repeat ($urandom_range(1, 6)) format_q.push_back(8'($urandom_range(0, 255)));
            return;
        end

        // introducer, any byte now and then
        if ($urandom_range(0, 99) < 90) begin
            put_text("%");
        end else begin
            format_q.push_back(8'($urandom_range(0, 255)));
        end

        // positional index, bare dollar, or a leading run read back as width
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            put_number();
            format_q.push_back(pcsp_pkg::C_DOLLAR);
        end else if (pick < 30) begin
            format_q.push_back(pcsp_pkg::C_DOLLAR);
        end else if (pick < 42) begin
            put_number();
            lead_width = 1'b1;
        end

        if (!lead_width) begin
            repeat ($urandom_range(0, 4)) begin
                format_q.push_back(flag_chars[$urandom_range(0, flag_chars.len() - 1)]);
            end

            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                // no width
            end else if (pick < 65) begin
                put_number();
            end else if (pick < 78) begin
                format_q.push_back(pcsp_pkg::C_STAR);
                put_number();
                format_q.push_back(pcsp_pkg::C_DOLLAR);
            end else if (pick < 84) begin
                format_q.push_back(pcsp_pkg::C_STAR);
                format_q.push_back(pcsp_pkg::C_DOLLAR);
            end else if (pick < 90) begin
                // star followed straight by the rest
                format_q.push_back(pcsp_pkg::C_STAR);
            end else begin
                // star run without dollar ends the spec
                format_q.push_back(pcsp_pkg::C_STAR);
                put_number();
                put_conversion();
                return;
            end
        end

        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            // no precision
        end else if (pick < 55) begin
            format_q.push_back(pcsp_pkg::C_DOT);
        end else if (pick < 75) begin
            format_q.push_back(pcsp_pkg::C_DOT);
            put_number();
        end else if (pick < 86) begin
            format_q.push_back(pcsp_pkg::C_DOT);
            format_q.push_back(pcsp_pkg::C_STAR);
            put_number();
            format_q.push_back(pcsp_pkg::C_DOLLAR);
        end else if (pick < 91) begin
            format_q.push_back(pcsp_pkg::C_DOT);
            format_q.push_back(pcsp_pkg::C_STAR);
            if ($urandom_range(0, 1) == 1) begin
                format_q.push_back(pcsp_pkg::C_DOLLAR);
            end
        end else begin
            format_q.push_back(pcsp_pkg::C_DOT);
            format_q.push_back(pcsp_pkg::C_STAR);
            put_number();
            put_conversion();
            return;
        end

        if ($urandom_range(0, 99) < 30) begin
            repeat ($urandom_range(1, 3)) begin
                format_q.push_back(($urandom_range(0, 1) == 1) ? pcsp_pkg::C_H
                                                                : pcsp_pkg::C_L);
            end
        end
        put_conversion();
    endtask

    // sender holds off until every predicted result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int goal;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: byte extremes as introducer and type, star run without
        // dollar, leading zero run taken as zero pad plus width, bare star
        // dollar precision, flag overrides, bare leading dollar
        format_q.push_back(8'h00);
        format_q.push_back(8'hFF);
        put_text("%*12x");
        put_text("%007.*$d");
        put_text("%-0+ '#lhc");
        put_text("%$d");
        flush_format();

        // rewind count saturates on a very long star run
        put_text("%*");
        put_digits(270);
        put_text("d");
        flush_format();

        for (int profile = 0; profile < 3; profile++) begin
            unique case (profile)
                0: begin
                    tx_idle_pct = 6;
                    rx_idle_pct <= 57;
                end
                1: begin
                    tx_idle_pct = 57;
                    rx_idle_pct <= 6;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                end
            endcase
            drain_results();
            goal = bytes_sent + BYTES_PER_PROFILE;
            while (bytes_sent < goal) begin
                put_spec();
                flush_format();
            end
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d format bytes, checked %0d results across three idling profiles",
                 bytes_sent, specs_seen);
        $display("covered flags, positional and star indexes, overflow and early-ending specs");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
